/* rtl/assert_macros.svh */
// shared assertion macros, clocked on clk with synchronous active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/mips_pkg.sv */
`timescale 1ns / 1ps
package mips_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int DIM         = 8;
  localparam int COORD_BITS  = 16;
  localparam int NUM_LANES   = 8;
  localparam int WEIGHT_BITS = 16;
  localparam int LANE_BITS   = 16;
  localparam int IN_BITS     = NUM_LANES * LANE_BITS;
  localparam int MULT_BITS   = COORD_BITS + WEIGHT_BITS;
  localparam int PAIR_BITS   = MULT_BITS + 1;
  localparam int PROD_BITS   = 35;
  localparam int IDX_BITS    = $clog2(MAX_POINTS);
  localparam int CNT_BITS    = IDX_BITS + 1;
  localparam int OUT_IDX_BITS = 6;
  localparam int OUT_BITS    = 48;
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_SUM,
    ST_UPD,
    ST_RD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic add;
    logic sum;
    logic upd;
    logic rd;
    logic adv;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic final_idx;
  } stat_t;

endpackage

/* rtl/mips_ctrl.sv */
`timescale 1ns / 1ps
module mips_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_tlast,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  mips_pkg::stat_t stat,
  output mips_pkg::cmd_t  cmd
);
  import mips_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (!stat.full) begin
            state_nxt = ST_MUL;
          end else if (in_tlast) begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_MUL: state_nxt = ST_ADD;
      ST_ADD: state_nxt = ST_SUM;
      ST_SUM: state_nxt = ST_UPD;
      ST_UPD: state_nxt = stat.last ? ST_RD : ST_IDLE;
      ST_RD:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_tready) begin
          state_nxt = stat.final_idx ? ST_IDLE : ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_MUL: cmd.mul = 1'b1;
      ST_ADD: cmd.add = 1'b1;
      ST_SUM: cmd.sum = 1'b1;
      ST_UPD: cmd.upd = 1'b1;
      ST_RD:  cmd.rd  = 1'b1;
      ST_OUT: begin
        out_tvalid = 1'b1;
        cmd.clr    = out_tready & stat.final_idx;
        cmd.adv    = out_tready & ~stat.final_idx;
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/mips_dp.sv */
`timescale 1ns / 1ps
module mips_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  mips_pkg::cmd_t                           cmd,
  output mips_pkg::stat_t                          stat,
  input  logic [mips_pkg::IN_BITS-1:0]             in_data,
  input  logic                                     in_last,
  input  logic                                     wgt_we,
  input  logic [2:0]                               wgt_sel,
  input  logic [mips_pkg::WEIGHT_BITS-1:0]         wgt_data,
  output logic [mips_pkg::WEIGHT_BITS-1:0]         wgt_rdata,
  output logic [mips_pkg::OUT_IDX_BITS-1:0]        point_index,
  output logic signed [mips_pkg::PROD_BITS-1:0]    min_product,
  output logic                                     overflowed,
  output logic                                     end_of_run
);
  import mips_pkg::*;

  logic signed [WEIGHT_BITS-1:0] weight_r [NUM_LANES];
  logic signed [COORD_BITS-1:0]  coord_r  [NUM_LANES];
  logic                          last_r;
  logic signed [MULT_BITS-1:0]   mult_r   [NUM_LANES];
  logic signed [PAIR_BITS-1:0]   pair_r   [NUM_LANES/2];
  logic signed [PROD_BITS-1:0]   ip_r;
  logic signed [PROD_BITS-1:0]   running_min_r;
  logic                          have_min_r;
  logic [CNT_BITS-1:0]           tie_count_r;
  logic [CNT_BITS-1:0]           point_cnt_r;
  logic                          ovf_r;
  logic [IDX_BITS-1:0]           emit_k_r;
  logic [IDX_BITS-1:0]           rd_data_r;
  logic [IDX_BITS-1:0]           tie_mem [MAX_POINTS];

  logic                          is_less;
  logic                          is_tie;
  logic                          mem_we;
  logic [IDX_BITS-1:0]           mem_waddr;

  // weight registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        weight_r[i] <= '0;
      end
    end else if (wgt_we) begin
      weight_r[wgt_sel] <= wgt_data;
    end
  end

  assign wgt_rdata = weight_r[wgt_sel];

  // point capture and product pipeline
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      last_r <= in_last;
      for (int d = 0; d < NUM_LANES; d++) begin
        coord_r[d] <= in_data[d*LANE_BITS +: COORD_BITS];
      end
    end
    if (cmd.mul) begin
      for (int d = 0; d < NUM_LANES; d++) begin
        mult_r[d] <= (d < DIM) ? MULT_BITS'(coord_r[d] * weight_r[d]) : '0;
      end
    end
    if (cmd.add) begin
      for (int p = 0; p < NUM_LANES/2; p++) begin
        pair_r[p] <= PAIR_BITS'(mult_r[2*p]) + PAIR_BITS'(mult_r[2*p+1]);
      end
    end
    if (cmd.sum) begin
      ip_r <= PROD_BITS'(pair_r[0]) + PROD_BITS'(pair_r[1])
            + PROD_BITS'(pair_r[2]) + PROD_BITS'(pair_r[3]);
    end
  end

  assign is_less = !have_min_r || (ip_r < running_min_r);
  assign is_tie  = (ip_r == running_min_r) && (tie_count_r < CNT_BITS'(MAX_POINTS));

  // running minimum and tie bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      running_min_r <= '0;
      have_min_r    <= 1'b0;
      tie_count_r   <= '0;
      point_cnt_r   <= '0;
      ovf_r         <= 1'b0;
      emit_k_r      <= '0;
    end else begin
      if (cmd.capture && stat.full) begin
        ovf_r <= 1'b1;
      end
      if (cmd.upd) begin
        point_cnt_r <= point_cnt_r + 1'b1;
        if (is_less) begin
          running_min_r <= ip_r;
          have_min_r    <= 1'b1;
          tie_count_r   <= CNT_BITS'(1);
        end else if (is_tie) begin
          tie_count_r <= tie_count_r + 1'b1;
        end
      end
      if (cmd.adv) begin
        emit_k_r <= emit_k_r + 1'b1;
      end
    end
  end

  assign mem_we    = cmd.upd && (is_less || is_tie);
  assign mem_waddr = is_less ? '0 : tie_count_r[IDX_BITS-1:0];

  // tie index store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tie_mem[mem_waddr] <= point_cnt_r[IDX_BITS-1:0];
    end
    if (cmd.rd) begin
      rd_data_r <= tie_mem[emit_k_r];
    end
  end

  assign stat.full      = (point_cnt_r >= CNT_BITS'(MAX_POINTS));
  assign stat.last      = last_r;
  assign stat.final_idx = ({1'b0, emit_k_r} + CNT_BITS'(1)) == tie_count_r;

  assign point_index = OUT_IDX_BITS'(rd_data_r);
  assign min_product = running_min_r;
  assign overflowed  = ovf_r;
  assign end_of_run  = stat.final_idx;

endmodule

/* rtl/min_inner_product_point_set_unit.sv */
`timescale 1ns / 1ps
// channel  | role                  | payload
// in_*     | point stream, slave   | tdata: coord_0..coord_7, tlast: last_point
// out_*    | tie list, master      | tdata: point_index, min_product, overflowed
//          |                       | tlast: end_of_run
// cfg_*    | weight registers      | weight_0..weight_7 at 4*i
//
// a stored point passes multiply, two adder stages and min compare between acceptance and
// the next ready; a point beyond capacity skips these stages and is not stored
// each result passes a tie store read and an output state, which holds through any out stall
// no input is taken while a set is being emitted
// synchronous active-low reset clears weights and set state; no clearing pass
`include "assert_macros.svh"
module min_inner_product_point_set_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [127:0] in_tdata,  // coord_0 .. coord_7, 16 bits each
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // point_index[5:0], min_product[40:6], overflowed[41]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [mips_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [mips_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [mips_pkg::APB_DW-1:0] cfg_prdata,
  output logic        cfg_pready
);
  import mips_pkg::*;

  cmd_t                         cmd;
  stat_t                        stat;
  logic                         wgt_we;
  logic [WEIGHT_BITS-1:0]       wgt_rdata;
  logic [OUT_IDX_BITS-1:0]      point_index;
  logic signed [PROD_BITS-1:0]  min_product;
  logic                         overflowed;
  logic                         end_of_run;

  assign cfg_pready = 1'b1;
  assign wgt_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = APB_DW'(wgt_rdata);

  mips_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  mips_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_data     (in_tdata),
    .in_last     (in_tlast),
    .wgt_we      (wgt_we),
    .wgt_sel     (cfg_paddr[4:2]),
    .wgt_data    (cfg_pwdata[WEIGHT_BITS-1:0]),
    .wgt_rdata   (wgt_rdata),
    .point_index (point_index),
    .min_product (min_product),
    .overflowed  (overflowed),
    .end_of_run  (end_of_run)
  );

  assign out_tdata = {(OUT_BITS - OUT_IDX_BITS - PROD_BITS - 1)'(0), overflowed,
                      min_product, point_index};
  assign out_tlast = end_of_run;

  `CHK_SAME(a_no_in_while_emit, out_tvalid, !in_tready)
  `CHK_NEXT(a_ready_after_end, out_tvalid && out_tready && out_tlast, in_tready)
  `CHK_SAME(a_ovf_needs_full, out_tvalid && overflowed, stat.full)
  `CHK_NEXT(a_emit_follows_last, in_tvalid && in_tready && in_tlast && stat.full, !in_tready)

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import mips_pkg::*;

  typedef enum int {
    LANE_WIDE,
    LANE_SMALL,
    LANE_EDGE
  } lane_mode_t;

  typedef struct packed {
    logic [5:0]  point_index;
    logic [34:0] min_product;
    logic        overflowed;
    logic        end_of_run;
  } tie_result_t;

  localparam int LONG_HOLD_CYCLES = 300;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;  // coord_0 .. coord_7, 16 bits each
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;  // point_index, min_product, overflowed
  logic         out_tlast;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [4:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  min_inner_product_point_set_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predictor copy of weights and set state
  logic [15:0] weight_q [8];
  logic [5:0]  tie_list [64];
  int          tie_cnt = 0;
  longint      run_min = 0;
  bit          have_min = 0;
  int          pts_in_set = 0;
  bit          set_ovf = 0;

  tie_result_t tie_q [$];

  int errors = 0;
  int points_sent = 0;
  int results_seen = 0;
  int weight_loads = 0;
  int long_holds = 0;
  bit hold_req = 0;
  bit calm = 0;

  initial begin
    for (int i = 0; i < 8; i++) weight_q[i] = '0;
  end

  task automatic track_min_point(input logic [127:0] coords, input bit last);
    longint ip;
    tie_result_t r;
    if (pts_in_set >= MAX_POINTS) begin
      set_ovf = 1;
    end else begin
      ip = 0;
      for (int d = 0; d < DIM; d++)
        ip += longint'($signed(coords[16*d +: 16])) * longint'($signed(weight_q[d]));
      if (!have_min || ip < run_min) begin
        run_min = ip;
        have_min = 1;
        tie_list[0] = 6'(pts_in_set);
        tie_cnt = 1;
      end else if (ip == run_min && tie_cnt < 64) begin
        tie_list[tie_cnt] = 6'(pts_in_set);
        tie_cnt++;
      end
      pts_in_set++;
    end
    if (last) begin
      for (int k = 0; k < tie_cnt; k++) begin
        r.point_index = tie_list[k];
        r.min_product = 35'(run_min);
        r.overflowed  = set_ovf;
        r.end_of_run  = (k == tie_cnt - 1);
        tie_q = {tie_q, r};
      end
      tie_cnt = 0;
      run_min = 0;
      have_min = 0;
      pts_in_set = 0;
      set_ovf = 0;
    end
  endtask

  task automatic send_point(input logic [127:0] coords, input bit last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= coords;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    track_min_point(coords, last);
    points_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    tie_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (tie_q.size() == 0) begin
        $error("unexpected result: point_index %0d", out_tdata[5:0]);
        errors++;
      end else begin
        want = tie_q.pop_front();
        if (out_tdata[5:0] !== want.point_index) begin
          $error("point_index expected %0d got %0d", want.point_index, out_tdata[5:0]);
          errors++;
        end
        if (out_tdata[40:6] !== want.min_product) begin
          $error("min_product expected %0d got %0d",
                 $signed(want.min_product), $signed(out_tdata[40:6]));
          errors++;
        end
        if (out_tdata[41] !== want.overflowed) begin
          $error("overflowed expected %0d got %0d", want.overflowed, out_tdata[41]);
          errors++;
        end
        if (out_tlast !== want.end_of_run) begin
          $error("end_of_run expected %0d got %0d", want.end_of_run, out_tlast);
          errors++;
        end
      end
    end
  end

  // receiver side: random stalls plus one long hold on request
  initial begin
    int hold_cnt;
    int burst;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < LONG_HOLD_CYCLES) begin
          @(posedge clk);
          hold_cnt++;
        end
        hold_req = 0;
        long_holds++;
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 15);
        out_tready <= 1'b0;
        repeat (burst) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

  task automatic apb_write(input int idx, input logic [15:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 5'(idx * 4);
    cfg_pwdata  <= {{16{val[15]}}, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    weight_q[idx] = val;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read_check(input int idx);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= 5'(idx * 4);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[15:0] !== weight_q[idx]) begin
      $error("weight_%0d expected %0d got %0d", idx, $signed(weight_q[idx]),
             $signed(cfg_prdata[15:0]));
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // block is idle once every tie result is out and the pipeline has drained
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (tie_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic load_weights(input logic [127:0] w);
    wait_idle();
    for (int i = 0; i < 8; i++) apb_write(i, w[16*i +: 16]);
    for (int i = 0; i < 8; i++) apb_read_check(i);
    weight_loads++;
  endtask

  function automatic logic [15:0] rand_lane(input lane_mode_t mode);
    logic [15:0] v;
    case (mode)
      LANE_WIDE:  v = 16'($urandom);
      LANE_SMALL: v = 16'($urandom_range(0, 4) - 2);
      default: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'hffff;
          3: v = 16'h0001;
          default: v = 16'h0000;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [127:0] rand_point(input lane_mode_t mode);
    logic [127:0] p;
    for (int d = 0; d < 8; d++) p[16*d +: 16] = rand_lane(mode);
    return p;
  endfunction

  function automatic logic [127:0] pack8(input logic [15:0] a, b, c, d, e, f, g, h);
    return {h, g, f, e, d, c, b, a};
  endfunction

  task automatic random_sets(input int budget);
    int len;
    logic [127:0] p;
    logic [127:0] prev;
    prev = '0;
    while (budget > 0) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        if (k > 0 && $urandom_range(0, 2) == 0)
          p = prev;
        else
          p = rand_point(lane_mode_t'($urandom_range(0, 2)));
        send_point(p, k == len - 1);
        prev = p;
      end
      budget -= len;
    end
  endtask

  task automatic test_reset_state();
    for (int i = 0; i < 8; i++) apb_read_check(i);
    // zero weights: every point ties at zero
    send_point(rand_point(LANE_WIDE), 0);
    send_point(rand_point(LANE_EDGE), 0);
    send_point(rand_point(LANE_WIDE), 1);
  endtask

  task automatic test_weight_extremes();
    load_weights({8{16'h8000}});
    send_point({8{16'h7fff}}, 0);
    send_point({8{16'h8000}}, 0);
    send_point({8{16'h7fff}}, 1);
    send_point({8{16'h8000}}, 1);
    load_weights({8{16'h7fff}});
    send_point({8{16'h8000}}, 1);
    send_point({8{16'h7fff}}, 0);
    send_point({8{16'h0000}}, 1);
    load_weights(pack8(16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                       16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
    send_point(pack8(16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                     16'h7fff, 16'h8000, 16'h7fff, 16'h8000), 0);
    send_point({8{16'hffff}}, 1);
  endtask

  task automatic test_tie_tracking();
    load_weights(pack8(16'd1, 16'd2, 16'd3, 16'd0, 16'd0, 16'd0, 16'd0, 16'hffff));
    send_point(pack8(16'd5, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0), 0);
    send_point(pack8(16'd1, 16'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0), 0);
    // strictly smaller clears the list
    send_point(pack8(16'd3, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0), 0);
    send_point(pack8(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0), 0);
    send_point(pack8(16'd7, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0), 0);
    send_point(pack8(16'd4, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1), 1);
  endtask

  task automatic test_capacity();
    logic [127:0] p;
    load_weights(rand_point(LANE_SMALL));
    // 64 stored ties, then ignored points with the last one flagged
    p = rand_point(LANE_WIDE);
    for (int k = 0; k < MAX_POINTS; k++) send_point(p, 0);
    send_point(rand_point(LANE_WIDE), 0);
    send_point({8{16'h8000}}, 1);
    // exactly full, last on the final stored point
    for (int k = 0; k < MAX_POINTS; k++)
      send_point(($urandom_range(0, 3) == 0) ? p : rand_point(LANE_SMALL),
                 k == MAX_POINTS - 1);
  endtask

  task automatic test_output_stall();
    logic [127:0] p;
    load_weights(rand_point(LANE_WIDE));
    hold_req = 1;
    p = rand_point(LANE_WIDE);
    for (int k = 0; k < 8; k++) send_point(p, k == 7);
    // these wait behind the held emission
    for (int k = 0; k < 6; k++) send_point(rand_point(LANE_SMALL), k == 5);
    while (hold_req) @(posedge clk);
  endtask

  task automatic test_random_mix();
    load_weights(rand_point(LANE_WIDE));
    random_sets(20);
    load_weights(rand_point(LANE_SMALL));
    random_sets(20);
    load_weights(rand_point(LANE_EDGE));
    random_sets(20);
  endtask

  task automatic test_steady_stream();
    load_weights(rand_point(LANE_SMALL));
    calm = 1;
    random_sets(30);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_weight_extremes();
    test_tie_tracking();
    test_capacity();
    test_output_stall();
    test_random_mix();
    test_steady_stream();
    wait_idle();
    repeat (20) @(posedge clk);
    $display("sent %0d points over %0d weight loads, checked %0d tie results",
             points_sent, weight_loads, results_seen);
    $display("long receiver holds: %0d, errors: %0d", long_holds, errors);
    if (errors == 0 && tie_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/mips_pkg.sv
rtl/mips_ctrl.sv
rtl/mips_dp.sv
rtl/min_inner_product_point_set_unit.sv
sim/tb_top.sv
